// ----- design/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, constants and drive tables for the lane position steering
// block.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int SENSOR_COUNT = 7;
  localparam int SAMPLE_W     = 12;
  localparam int POS_W        = 4;
  localparam int WIN_W        = 3;
  localparam int DUTY_W       = 10;
  localparam int TAIL_W       = 3;
  localparam int CFG_IDX_W    = 2;

  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 32;

  localparam logic [POS_W-1:0] NO_POSITION   = 4'd8;
  localparam logic [POS_W-1:0] POS_RST       = 4'd0;

  localparam logic [SAMPLE_W-1:0] LOST_LEVEL_RST    = 12'd950;
  localparam logic [SAMPLE_W-1:0] WEAK_LEVEL_RST    = 12'd1300;
  localparam logic [SAMPLE_W-1:0] PRESENT_LEVEL_RST = 12'd1301;
  localparam logic [SAMPLE_W-1:0] STRONG_LEVEL_RST  = 12'd1400;

  typedef enum logic [TAIL_W-1:0] {
    TAIL_FWD   = 3'd0,
    TAIL_LEFT  = 3'd2,
    TAIL_RIGHT = 3'd3,
    TAIL_STOP  = 3'd4
  } tail_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOST_LEVEL    = 2'd0,
    CFG_WEAK_LEVEL    = 2'd1,
    CFG_PRESENT_LEVEL = 2'd2,
    CFG_STRONG_LEVEL  = 2'd3
  } cfg_index_t;

  typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] samples_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lost_level;
    logic [SAMPLE_W-1:0] weak_level;
    logic [SAMPLE_W-1:0] present_level;
    logic [SAMPLE_W-1:0] strong_level;
  } levels_t;

  typedef struct packed {
    logic             lost;
    logic             all_weak;
    logic             hit;
    logic [WIN_W-1:0] winner;
  } class_t;

  typedef struct packed {
    logic              indicator;
    tail_mode_t        tail_mode;
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic              lost;
    logic [POS_W-1:0]  position;
  } result_t;

  function automatic logic [DUTY_W-1:0] left_duty_f(input logic [WIN_W-1:0] pos);
    logic [DUTY_W-1:0] d;
    case (pos)
      3'd0:    d = 10'd950;
      3'd1:    d = 10'd900;
      3'd2:    d = 10'd800;
      3'd3:    d = 10'd780;
      3'd4:    d = 10'd800;
      3'd5:    d = 10'd758;
      3'd6:    d = 10'd680;
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [DUTY_W-1:0] right_duty_f(input logic [WIN_W-1:0] pos);
    logic [DUTY_W-1:0] d;
    case (pos)
      3'd0:    d = 10'd600;
      3'd1:    d = 10'd640;
      3'd2:    d = 10'd700;
      3'd3:    d = 10'd705;
      3'd4:    d = 10'd720;
      3'd5:    d = 10'd850;
      3'd6:    d = 10'd920;
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic tail_mode_t tail_mode_f(input logic [WIN_W-1:0] pos);
    tail_mode_t t;
    case (pos)
      3'd0, 3'd1, 3'd2: t = TAIL_RIGHT;
      3'd3:             t = TAIL_FWD;
      3'd4, 3'd5, 3'd6: t = TAIL_LEFT;
      default:          t = TAIL_STOP;
    endcase
    return t;
  endfunction

endpackage

// ----- design/lane_position_steering.sv -----
// ----------------------------------------------------------------------------
// lane_position_steering
// Magnet sensor lane tracking: classifies each frame of seven samples and
// drives the motor duties and tail-light mode.
//
// channel  dir  payload
// in_*     in   seven samples and run flag, one frame per word
// out_*    out  position, lost, left/right duty, tail mode, indicator
// cfg_*    in   lost, weak, present and strong levels
//
// One word per cycle sustained while out_tready stays high; a word passes the input
// register, classify and update, and the result register.
// Synchronous active-low reset restores levels and state, empties both stages.
// A stalled result stage keeps the input stage filled; in_tready drops only
// when both stages hold a word.
// ----------------------------------------------------------------------------
module lane_position_steering (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sample_0[11:0] .. sample_6[83:72], running[84], zero pad
  input  logic [lps_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // position[3:0], lost[4], left_duty[14:5], right_duty[24:15],
  // tail_mode[27:25], indicator[28], zero pad
  output logic [lps_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lps_pkg::SAMPLE_W-1:0]     cfg_wdata
);

  localparam int SAMPLES_W = lps_pkg::SENSOR_COUNT * lps_pkg::SAMPLE_W;
  localparam int RES_W     = $bits(lps_pkg::result_t);

  lps_pkg::levels_t  levels_r;
  logic              s1_valid_r;
  lps_pkg::samples_t s1_samples_r;
  logic              s1_running_r;
  logic              out_valid_r, out_valid_nxt;
  lps_pkg::result_t  out_res_r;
  lps_pkg::class_t   cls;
  lps_pkg::result_t  res;
  logic              adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r.lost_level    <= lps_pkg::LOST_LEVEL_RST;
      levels_r.weak_level    <= lps_pkg::WEAK_LEVEL_RST;
      levels_r.present_level <= lps_pkg::PRESENT_LEVEL_RST;
      levels_r.strong_level  <= lps_pkg::STRONG_LEVEL_RST;
    end else if (cfg_we) begin
      case (lps_pkg::cfg_index_t'(cfg_index))
        lps_pkg::CFG_LOST_LEVEL:    levels_r.lost_level    <= cfg_wdata;
        lps_pkg::CFG_WEAK_LEVEL:    levels_r.weak_level    <= cfg_wdata;
        lps_pkg::CFG_PRESENT_LEVEL: levels_r.present_level <= cfg_wdata;
        lps_pkg::CFG_STRONG_LEVEL:  levels_r.strong_level  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_samples_r <= in_tdata[SAMPLES_W-1:0];
      s1_running_r <= in_tdata[SAMPLES_W];
    end
  end

  lps_classify u_classify (
    .samples (s1_samples_r),
    .levels  (levels_r),
    .cls     (cls)
  );

  lps_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cls     (cls),
    .running (s1_running_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lps_pkg::OUT_DATA_W - RES_W){1'b0}}, out_res_r};

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_samples_r))
    else $error("input stage word lost while stalled");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("advanced word not presented");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("accepted a word with both stages full");

endmodule

// ----- design/lps_classify.sv -----
// ----------------------------------------------------------------------------
// lps_classify
// Frame classification: lost and weak checks and the sensor priority cascade.
// ----------------------------------------------------------------------------
module lps_classify (
  input  lps_pkg::samples_t samples,
  input  lps_pkg::levels_t  levels,
  output lps_pkg::class_t   cls
);

  logic [lps_pkg::SENSOR_COUNT-1:0] below_lost;
  logic [lps_pkg::SENSOR_COUNT-1:0] below_weak;
  logic [lps_pkg::SENSOR_COUNT-1:0] above_strong;
  logic [lps_pkg::SENSOR_COUNT-1:0] present;
  logic [lps_pkg::SENSOR_COUNT-1:0] sel;

  always_comb begin
    for (int k = 0; k < lps_pkg::SENSOR_COUNT; k++) begin
      below_lost[k]   = samples[k] < levels.lost_level;
      below_weak[k]   = samples[k] < levels.weak_level;
      above_strong[k] = samples[k] > levels.strong_level;
      present[k]      = samples[k] > levels.present_level;
    end
  end

  // differences against the center sensor reduce to plain sample compares
  always_comb begin
    sel[0] = above_strong[0] | (present[0] & (samples[0] > samples[1]));
    sel[1] = above_strong[1] | (present[1] & ((samples[1] > samples[3]) |
                                              (samples[1] < samples[2])));
    sel[2] = above_strong[2] | (present[2] & (samples[2] > samples[3]));
    sel[3] = above_strong[3] | (present[3] & ((samples[2] < samples[3]) |
                                              (samples[4] < samples[3])));
    sel[4] = above_strong[4] | (present[4] & ((samples[4] > samples[3]) |
                                              (samples[4] > samples[5])));
    sel[5] = above_strong[5] | (present[5] & ((samples[5] > samples[3]) |
                                              (samples[5] > samples[6])));
    sel[6] = above_strong[6] | (present[6] & (samples[6] > samples[3]));
  end

  always_comb begin
    cls.lost     = |below_lost;
    cls.all_weak = &below_weak;
    cls.hit      = |sel;
    cls.winner   = '0;
    for (int k = lps_pkg::SENSOR_COUNT - 1; k >= 0; k--) begin
      if (sel[k]) begin
        cls.winner = lps_pkg::WIN_W'(k);
      end
    end
  end

endmodule

// ----- design/lps_state.sv -----
// ----------------------------------------------------------------------------
// lps_state
// Position, held position, indicator and drive registers, and the result
// word built from their next values.
// ----------------------------------------------------------------------------
module lps_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  lps_pkg::class_t   cls,
  input  logic              running,
  output lps_pkg::result_t  res
);

  logic [lps_pkg::POS_W-1:0]  cur_pos_r,   cur_pos_nxt;
  logic [lps_pkg::POS_W-1:0]  held_pos_r,  held_pos_nxt;
  logic                       indicator_r, indicator_nxt;
  logic [lps_pkg::DUTY_W-1:0] left_r,      left_nxt;
  logic [lps_pkg::DUTY_W-1:0] right_r,     right_nxt;
  lps_pkg::tail_mode_t        tail_r,      tail_nxt;

  always_comb begin
    cur_pos_nxt   = cur_pos_r;
    held_pos_nxt  = held_pos_r;
    indicator_nxt = indicator_r;
    if (!cls.lost) begin
      if (cls.all_weak) begin
        cur_pos_nxt   = held_pos_r;
        indicator_nxt = 1'b0;
      end else if (cls.hit) begin
        cur_pos_nxt   = {1'b0, cls.winner};
        held_pos_nxt  = {1'b0, cls.winner};
        indicator_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    tail_nxt  = tail_r;
    if (cls.lost || !running) begin
      left_nxt  = '0;
      right_nxt = '0;
      tail_nxt  = lps_pkg::TAIL_STOP;
    end else if (cur_pos_nxt < lps_pkg::POS_W'(lps_pkg::SENSOR_COUNT)) begin
      left_nxt  = lps_pkg::left_duty_f(cur_pos_nxt[lps_pkg::WIN_W-1:0]);
      right_nxt = lps_pkg::right_duty_f(cur_pos_nxt[lps_pkg::WIN_W-1:0]);
      tail_nxt  = lps_pkg::tail_mode_f(cur_pos_nxt[lps_pkg::WIN_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r   <= lps_pkg::POS_RST;
      held_pos_r  <= lps_pkg::NO_POSITION;
      indicator_r <= 1'b0;
      left_r      <= '0;
      right_r     <= '0;
      tail_r      <= lps_pkg::TAIL_STOP;
    end else if (adv) begin
      cur_pos_r   <= cur_pos_nxt;
      held_pos_r  <= held_pos_nxt;
      indicator_r <= indicator_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_comb begin
    res.position   = cur_pos_nxt;
    res.lost       = cls.lost;
    res.left_duty  = left_nxt;
    res.right_duty = right_nxt;
    res.tail_mode  = tail_nxt;
    res.indicator  = indicator_nxt;
  end

  a_lost_stops: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cls.lost |=> tail_r == lps_pkg::TAIL_STOP && left_r == '0 && right_r == '0)
    else $error("lost frame did not stop the drive");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_pos_r < lps_pkg::POS_W'(lps_pkg::SENSOR_COUNT) || held_pos_r == lps_pkg::NO_POSITION)
    else $error("held position out of range");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cur_pos_r) && $stable(held_pos_r) && $stable(indicator_r))
    else $error("state changed without a word");

  a_ind_hit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && $past(adv) && !indicator_r && indicator_nxt |-> cls.hit && !cls.lost)
    else $error("indicator set without a match");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks lane_position_steering against a behavioral predictor of the
// frame classification, position hold and drive table logic. Directed frames
// cover every cascade position, weak, lost, no-match and stopped cases; then
// random frames run under several level settings with random stalls on both
// sides, and a final stretch streams without stalls.
// ----------------------------------------------------------------------------
module testbench;
  import lps_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // sample_0[11:0] .. sample_6[83:72], running[84], zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // position[3:0], lost[4], left_duty[14:5], right_duty[24:15],
  // tail_mode[27:25], indicator[28], zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_LOST_LEVEL;
  logic [SAMPLE_W-1:0]   cfg_wdata = '0;

  // predictor state
  logic [SAMPLE_W-1:0] lvl_lost = LOST_LEVEL_RST;
  logic [SAMPLE_W-1:0] lvl_weak = WEAK_LEVEL_RST;
  logic [SAMPLE_W-1:0] lvl_present = PRESENT_LEVEL_RST;
  logic [SAMPLE_W-1:0] lvl_strong = STRONG_LEVEL_RST;
  logic [POS_W-1:0]    lane_pos = POS_RST;
  logic [POS_W-1:0]    held_pos = NO_POSITION;
  logic [DUTY_W-1:0]   duty_l = '0;
  logic [DUTY_W-1:0]   duty_r = '0;
  tail_mode_t          tail_now = TAIL_STOP;
  logic                ind_now = 1'b0;

  result_t     pending_steer[$];
  int unsigned fails = 0;
  bit          idle_on = 1'b1;
  int          hold_left = 0;
  int unsigned quiet_cycles = 0;

  lane_position_steering uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first sensor that wins the cascade, -1 if none
  function automatic int lead_sensor(samples_t s);
    int d [SENSOR_COUNT];
    bit st [SENSOR_COUNT];
    bit pr [SENSOR_COUNT];
    int k;
    for (k = 0; k < SENSOR_COUNT; k++) begin
      d[k]  = int'(s[k]) - int'(s[3]);
      st[k] = s[k] > lvl_strong;
      pr[k] = s[k] > lvl_present;
    end
    if (st[0] || (pr[0] && d[0] > d[1])) return 0;
    if (st[1] || (pr[1] && (d[1] > 0 || d[1] < d[2]))) return 1;
    if (st[2] || (pr[2] && d[2] > 0)) return 2;
    if (st[3] || (pr[3] && (d[2] < 0 || d[4] < 0))) return 3;
    if (st[4] || (pr[4] && (d[4] > 0 || d[4] > d[5]))) return 4;
    if (st[5] || (pr[5] && (d[5] > 0 || d[5] > d[6]))) return 5;
    if (st[6] || (pr[6] && d[6] > 0)) return 6;
    return -1;
  endfunction

  task automatic steer_frame(samples_t s, logic run);
    bit      lost_now;
    bit      weak_all;
    int      win;
    int      k;
    result_t r;
    lost_now = 1'b0;
    weak_all = 1'b1;
    for (k = 0; k < SENSOR_COUNT; k++) begin
      if (s[k] < lvl_lost) lost_now = 1'b1;
      if (s[k] >= lvl_weak) weak_all = 1'b0;
    end
    if (!lost_now) begin
      if (weak_all) begin
        lane_pos = held_pos;
        ind_now  = 1'b0;
      end else begin
        win = lead_sensor(s);
        if (win >= 0) begin
          lane_pos = win[POS_W-1:0];
          held_pos = win[POS_W-1:0];
          ind_now  = 1'b1;
        end
      end
    end
    if (lost_now || !run) begin
      duty_l   = '0;
      duty_r   = '0;
      tail_now = TAIL_STOP;
    end else begin
      case (lane_pos)
        4'd0: begin
          duty_l = 10'd950; duty_r = 10'd600; tail_now = TAIL_RIGHT;
        end
        4'd1: begin
          duty_l = 10'd900; duty_r = 10'd640; tail_now = TAIL_RIGHT;
        end
        4'd2: begin
          duty_l = 10'd800; duty_r = 10'd700; tail_now = TAIL_RIGHT;
        end
        4'd3: begin
          duty_l = 10'd780; duty_r = 10'd705; tail_now = TAIL_FWD;
        end
        4'd4: begin
          duty_l = 10'd800; duty_r = 10'd720; tail_now = TAIL_LEFT;
        end
        4'd5: begin
          duty_l = 10'd758; duty_r = 10'd850; tail_now = TAIL_LEFT;
        end
        4'd6: begin
          duty_l = 10'd680; duty_r = 10'd920; tail_now = TAIL_LEFT;
        end
        default: begin
        end
      endcase
    end
    r.position   = lane_pos;
    r.lost       = lost_now;
    r.left_duty  = duty_l;
    r.right_duty = duty_r;
    r.tail_mode  = tail_now;
    r.indicator  = ind_now;
    pending_steer.push_back(r);
  endtask

  task automatic send_frame(samples_t s, logic run);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tdata  <= {3'b000, run, s};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    steer_frame(s, run);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_level(cfg_index_t idx, logic [SAMPLE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOST_LEVEL:    lvl_lost = v;
      CFG_WEAK_LEVEL:    lvl_weak = v;
      CFG_PRESENT_LEVEL: lvl_present = v;
      CFG_STRONG_LEVEL:  lvl_strong = v;
      default: begin
      end
    endcase
  endtask

  task automatic set_levels(int lost_v, int weak_v, int present_v, int strong_v);
    drain_results();
    set_level(CFG_LOST_LEVEL, lost_v[SAMPLE_W-1:0]);
    set_level(CFG_WEAK_LEVEL, weak_v[SAMPLE_W-1:0]);
    set_level(CFG_PRESENT_LEVEL, present_v[SAMPLE_W-1:0]);
    set_level(CFG_STRONG_LEVEL, strong_v[SAMPLE_W-1:0]);
  endtask

  // sample near one of the levels, anywhere in range, or at an extreme
  function automatic logic [SAMPLE_W-1:0] level_sample(bit keep_found);
    int base;
    int jitter;
    int v;
    case ($urandom_range(0, 5))
      0: base = lvl_lost;
      1: base = lvl_weak;
      2: base = lvl_present;
      3: base = lvl_strong;
      4: base = $urandom_range(0, 4095);
      default: base = $urandom_range(0, 1) ? 4095 : 0;
    endcase
    jitter = $urandom_range(0, 40);
    v = base + jitter - 20;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    if (keep_found && v < lvl_lost) v = $urandom_range(lvl_lost, 4095);
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] quiet_sample();
    if (lvl_lost <= lvl_present) return SAMPLE_W'($urandom_range(lvl_lost, lvl_present));
    return level_sample(1'b1);
  endfunction

  function automatic logic [SAMPLE_W-1:0] weak_sample();
    if (lvl_weak > lvl_lost) return SAMPLE_W'($urandom_range(lvl_lost, lvl_weak - 1));
    return level_sample(1'b1);
  endfunction

  task automatic send_random(int n);
    samples_t s;
    int       kind;
    int       lead;
    int       k;
    repeat (n) begin
      kind = $urandom_range(0, 9);
      lead = $urandom_range(0, SENSOR_COUNT - 1);
      for (k = 0; k < SENSOR_COUNT; k++) begin
        if (kind < 6) begin
          s[k] = (k < lead) ? quiet_sample() : level_sample(1'b1);
        end else if (kind < 8) begin
          s[k] = weak_sample();
        end else begin
          s[k] = $urandom_range(0, 1) ? SAMPLE_W'($urandom()) : level_sample(1'b0);
        end
      end
      send_frame(s, $urandom_range(0, 9) != 0);
    end
  endtask

  // weak, lost, stopped and extreme frames at reset levels
  task automatic test_frame_classes();
    samples_t s;
    s = {SENSOR_COUNT{12'd1000}};
    send_frame(s, 1'b1);
    s[4] = 12'd949;
    send_frame(s, 1'b1);
    send_frame({SENSOR_COUNT{12'd0}}, 1'b1);
    send_frame({SENSOR_COUNT{12'hFFF}}, 1'b0);
    send_frame({SENSOR_COUNT{12'hFFF}}, 1'b1);
    send_frame({SENSOR_COUNT{12'd1000}}, 1'b1);
    s = {SENSOR_COUNT{12'd1000}};
    s[5] = 12'd1500;
    send_frame(s, 1'b0);
  endtask

  // strong win at each sensor, then each present/difference test
  task automatic test_cascade_positions();
    samples_t s;
    int       k;
    for (k = 0; k < SENSOR_COUNT; k++) begin
      s = {SENSOR_COUNT{12'd1000}};
      s[k] = 12'd1500;
      send_frame(s, 1'b1);
    end
    for (k = 0; k < SENSOR_COUNT; k++) begin
      s = {SENSOR_COUNT{12'd1000}};
      s[k] = 12'd1350;
      send_frame(s, 1'b1);
    end
    s = {SENSOR_COUNT{12'd1000}};
    s[1] = 12'd1340; s[2] = 12'd1350; s[3] = 12'd1345;
    send_frame(s, 1'b1);
    s = {SENSOR_COUNT{12'd1000}};
    s[2] = 12'd1350; s[3] = 12'd1350; s[4] = 12'd1350;
    send_frame(s, 1'b1);
    // no sensor matches
    s = {SENSOR_COUNT{12'd1350}};
    s[0] = 12'd1000; s[1] = 12'd1000;
    send_frame(s, 1'b1);
  endtask

  task automatic test_level_settings();
    int a;
    int b;
    int c;
    set_levels(0, 0, 0, 0);
    send_random(100);
    set_levels(4095, 4095, 4095, 4095);
    send_random(100);
    set_levels(2000, 1500, 1200, 1000);
    send_random(100);
    a = $urandom_range(0, 2000);
    b = a + $urandom_range(0, 600);
    c = b + $urandom_range(0, 400);
    set_levels(a, b, c, c + $urandom_range(0, 600));
    send_random(100);
    set_levels($urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095));
    send_random(100);
    set_levels(LOST_LEVEL_RST, WEAK_LEVEL_RST, PRESENT_LEVEL_RST, STRONG_LEVEL_RST);
    send_random(100);
  endtask

  task automatic test_random_traffic();
    send_random(600);
    drain_results();
    send_random(400);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    send_random(200);
  endtask

  task automatic check_field(string f, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, f, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[28:0];
      if (pending_steer.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
        fails++;
      end else begin
        want = pending_steer.pop_front();
        check_field("position", want.position, got.position);
        check_field("lost", want.lost, got.lost);
        check_field("left_duty", want.left_duty, got.left_duty);
        check_field("right_duty", want.right_duty, got.right_duty);
        check_field("tail_mode", want.tail_mode, got.tail_mode);
        check_field("indicator", want.indicator, got.indicator);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d words outstanding", $time, pending_steer.size());
    $display("FAIL lane_position_steering");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_classes();
    test_cascade_positions();
    test_level_settings();
    test_random_traffic();
    test_steady_stream();
    drain_results();
    repeat (6) @(posedge clk);
    if (fails == 0) begin
      $display("PASS lane_position_steering");
    end else begin
      $display("FAIL lane_position_steering");
    end
    $finish;
  end

endmodule
